FILE: hdl/ucplc_pkg.sv
// shared types and constants for the use-count pruned lookup cache
`default_nettype none
package ucplc_pkg;
	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 21;
	localparam int PAY_W = 32;
	localparam int USE_W = 16;
	localparam int OUT_W = 7;
	localparam int ENT_W = KEY_W + USE_W + PAY_W;
	localparam logic [USE_W-1:0] USES_MAX = '1;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_PRUNE  = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PRUNE,
		ST_PLACE,
		ST_DONE
	} state_t;

	// saturate a count to the output width
	function automatic logic [OUT_W-1:0] sat_out(input logic [CNT_W-1:0] v);
		if (CNT_W > OUT_W && v > CNT_W'((1 << OUT_W) - 1))
			return '1;
		return OUT_W'(v);
	endfunction
endpackage
`default_nettype wire

FILE: hdl/ucplc_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module ucplc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/use_count_pruned_lookup_cache.sv
// top level of the use-count pruned lookup cache
//  channel | dir | signals                 | contents
//  request | in  | s_axis_*, tdata 72 bits | req_type, codepoint, payload_in, prune_threshold
//  result  | out | m_axis_*, tdata 48 bits | hit, payload_out, removed_count, occupancy
// one item at a time; a lookup, insert or prune sweeps the entry ram once or twice, one entry a cycle,
// through a simple dual-port ram with registered read; a clear needs no sweep, and an insert into a
// full table takes a min scan, a prune sweep, then place
// reset empties the table at once through per-entry valid flip-flops
// the result waits in an output register; a stalled result holds the block idle
`default_nettype none
module use_count_pruned_lookup_cache (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// req_type[1:0], codepoint[22:2], payload_in[54:23], prune_threshold[70:55]
	input  wire logic [71:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// hit[0], payload_out[32:1], removed_count[39:33], occupancy[46:40]
	output      logic [47:0] m_axis_tdata
);
	import ucplc_pkg::*;

	state_t state_q, state_d;
	req_t req_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [USE_W-1:0] thr_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0] live_q, removed_q;
	logic [IDX_W:0] cnt_q;           // read address counter, equal to depth (one past the last address) at end
	logic rd_s1;                      // read data valid
	logic [IDX_W-1:0] ridx_s1;
	logic [USE_W-1:0] min_q;
	logic hit_q;
	logic [PAY_W-1:0] pout_q;
	logic out_v_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [ENT_W-1:0] wdata, rdata;
	logic [KEY_W-1:0] r_key;
	logic [USE_W-1:0] r_use;
	logic [PAY_W-1:0] r_pay;
	logic [IDX_W-1:0] free_idx;
	logic free_any;
	logic scan_end;

	assign {r_pay, r_use, r_key} = rdata;
	assign raddr = cnt_q[IDX_W-1:0];
	assign scan_end = (cnt_q == (IDX_W+1)'(CAPACITY));

	ucplc_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	logic match;
	assign match = rd_s1 && valid_q[ridx_s1] && r_key == key_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_axis_tvalid && !out_v_q) begin
				if (req_t'(s_axis_tdata[1:0]) == REQ_CLEAR) state_d = ST_DONE;
				else if (req_t'(s_axis_tdata[1:0]) == REQ_PRUNE) state_d = ST_PRUNE;
				else state_d = ST_SCAN;
			end
			ST_SCAN:  if (match) state_d = ST_DONE;
				else if (scan_end && !rd_s1) begin
					if (req_q == REQ_LOOKUP) state_d = ST_DONE;
					else if (live_q >= CNT_W'(CAPACITY)) state_d = ST_PRUNE;
					else state_d = ST_PLACE;
				end
			ST_PRUNE: if (scan_end && !rd_s1)
				state_d = (req_q == REQ_INSERT) ? ST_PLACE : ST_DONE;
			ST_PLACE: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	logic [USE_W-1:0] pthr;
	assign pthr = (req_q == REQ_INSERT) ? ((min_q < USE_W'(1)) ? USE_W'(1) : min_q) : thr_q;

	always_comb begin
		we = 1'b0;
		waddr = ridx_s1;
		wdata = rdata;
		if (state_q == ST_SCAN && match && r_use != USES_MAX) begin
			we = 1'b1;
			wdata = {r_pay, r_use + USE_W'(1), r_key};
		end else if (state_q == ST_PLACE && free_any) begin
			we = 1'b1;
			waddr = free_idx;
			wdata = {pay_q, {USE_W{1'b0}}, key_q};
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {1'b0, sat_out(live_q), sat_out(removed_q), pout_q, hit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			live_q <= '0;
			out_v_q <= 1'b0;
			rd_s1 <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && m_axis_tready)
				out_v_q <= 1'b0;
			rd_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: if (state_d != ST_IDLE) begin
					cnt_q <= '0;
					if (state_d == ST_DONE) begin
						valid_q <= '0;
						live_q <= '0;
					end
				end
				ST_SCAN, ST_PRUNE: begin
					if (!scan_end) begin
						cnt_q <= cnt_q + (IDX_W+1)'(1);
						rd_s1 <= 1'b1;
					end
					if (state_q == ST_PRUNE && rd_s1 && valid_q[ridx_s1]
							&& r_use <= pthr) begin
						valid_q[ridx_s1] <= 1'b0;
						live_q <= live_q - CNT_W'(1);
					end
					if (state_d != state_q) cnt_q <= '0;
				end
				ST_PLACE: if (free_any) begin
					valid_q[free_idx] <= 1'b1;
					live_q <= live_q + CNT_W'(1);
				end
				ST_DONE: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= raddr;
		case (state_q)
			// load a new item only when it is accepted, so a waiting result holds
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				req_q <= req_t'(s_axis_tdata[1:0]);
				key_q <= s_axis_tdata[22:2];
				pay_q <= s_axis_tdata[54:23];
				thr_q <= s_axis_tdata[70:55];
				hit_q <= 1'b0;
				pout_q <= '0;
				removed_q <= '0;
				min_q <= USES_MAX;
			end
			ST_SCAN: begin
				if (match) begin
					hit_q <= 1'b1;
					pout_q <= r_pay;
				end
				if (rd_s1 && valid_q[ridx_s1] && r_use < min_q)
					min_q <= r_use;
			end
			ST_PRUNE: if (rd_s1 && valid_q[ridx_s1] && r_use <= pthr)
				removed_q <= removed_q + CNT_W'(1);
			ST_PLACE: pout_q <= pay_q;
			default: ;
		endcase
	end
endmodule
`default_nettype wire
